### hw/rtl/assert_macros.svh
// Assertion macros used by the card classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define LCC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define LCC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/lcc_pkg.sv
// Types and constants of the card classifier.
`timescale 1ns / 1ps

package lcc_pkg;

    // Width of the card number field and of the part that is converted to decimal.
    localparam int CARD_BITS      = 63;
    localparam int VALUE_BITS     = 57;
    // Binary bits consumed by each stage of the decimal converter.
    localparam int BITS_PER_STAGE = 3;
    localparam int STAGE_COUNT    = VALUE_BITS / BITS_PER_STAGE;

    // Range and length boundaries.
    localparam logic [CARD_BITS-1:0] LOW_BOUND  = 63'd1000000000000;
    localparam logic [CARD_BITS-1:0] HIGH_BOUND = 63'd99999999999999999;
    localparam logic [CARD_BITS-1:0] TEN_POW_12 = 63'd1000000000000;
    localparam logic [CARD_BITS-1:0] TEN_POW_13 = 63'd10000000000000;
    localparam logic [CARD_BITS-1:0] TEN_POW_14 = 63'd100000000000000;
    localparam logic [CARD_BITS-1:0] TEN_POW_15 = 63'd1000000000000000;
    localparam logic [CARD_BITS-1:0] TEN_POW_16 = 63'd10000000000000000;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_VISA    = 2'd1,
        KIND_MASTER  = 2'd2,
        KIND_AMEX    = 2'd3
    } card_kind_t;

    // Payload of one input beat.
    typedef struct packed {
        logic [CARD_BITS-1:0] card_number;
    } card_beat_t;

    // Payload of one result beat.
    typedef struct packed {
        card_kind_t card_kind;
        logic       luhn_ok;
    } result_beat_t;

    // Range and length flags that travel with a number down the pipeline.
    typedef struct packed {
        logic in_range;
        logic len16;
        logic len15;
        logic len13;
    } tag_t;

    // Doubled Luhn digit with the digits of the product added.
    function automatic logic [3:0] luhn_double(input logic [3:0] digit);
        logic [3:0] res;
        case (digit)
            4'd0:    res = 4'd0;
            4'd1:    res = 4'd2;
            4'd2:    res = 4'd4;
            4'd3:    res = 4'd6;
            4'd4:    res = 4'd8;
            4'd5:    res = 4'd1;
            4'd6:    res = 4'd3;
            4'd7:    res = 4'd5;
            4'd8:    res = 4'd7;
            4'd9:    res = 4'd9;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/lcc_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
`timescale 1ns / 1ps

interface lcc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

### hw/rtl/lcc_bcd_pipe.sv
// Pipelined binary to decimal converter using shift and add-three steps.
`timescale 1ns / 1ps

module lcc_bcd_pipe
    import lcc_pkg::*;
#(
    parameter int DIGIT_COUNT = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  tag_t                     in_tag,
    input  logic [VALUE_BITS-1:0]    in_value,
    output logic                     out_valid,
    output tag_t                     out_tag,
    output logic [4*DIGIT_COUNT-1:0] out_bcd
);

    localparam int BCD_BITS  = 4 * DIGIT_COUNT;
    localparam int WORK_BITS = BCD_BITS + VALUE_BITS;

    logic                  stage_valid_reg  [STAGE_COUNT];
    logic                  stage_valid_next [STAGE_COUNT];
    tag_t                  stage_tag_reg    [STAGE_COUNT];
    tag_t                  stage_tag_next   [STAGE_COUNT];
    logic [BCD_BITS-1:0]   stage_bcd_reg    [STAGE_COUNT];
    logic [BCD_BITS-1:0]   stage_bcd_next   [STAGE_COUNT];
    logic [VALUE_BITS-1:0] stage_bin_reg    [STAGE_COUNT];
    logic [VALUE_BITS-1:0] stage_bin_next   [STAGE_COUNT];

    // One stage worth of double-dabble steps. Digits that overflow the top
    // drop out, which leaves the low decimal digits exact.
    function automatic logic [WORK_BITS-1:0] dabble(
        input logic [BCD_BITS-1:0]   bcd,
        input logic [VALUE_BITS-1:0] bin
    );
        logic [WORK_BITS-1:0] work;
        logic [3:0]           digit;
        work = {bcd, bin};
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                digit = work[VALUE_BITS + 4*d +: 4];
                if (digit >= 4'd5) begin
                    work[VALUE_BITS + 4*d +: 4] = digit + 4'd3;
                end
            end
            work = work << 1;
        end
        return work;
    endfunction

    // Next contents of every stage, each fed from the one before it.
    always_comb
    begin
        for (int s = 0; s < STAGE_COUNT; s++) begin
            if (s == 0) begin
                stage_valid_next[s] = in_valid;
                stage_tag_next[s]   = in_tag;
                {stage_bcd_next[s], stage_bin_next[s]} = dabble('0, in_value);
            end else begin
                stage_valid_next[s] = stage_valid_reg[s-1];
                stage_tag_next[s]   = stage_tag_reg[s-1];
                {stage_bcd_next[s], stage_bin_next[s]} =
                    dabble(stage_bcd_reg[s-1], stage_bin_reg[s-1]);
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < STAGE_COUNT; s++) begin
                stage_valid_reg[s] <= 1'b0;
            end
        end else if (advance) begin
            for (int s = 0; s < STAGE_COUNT; s++) begin
                stage_valid_reg[s] <= stage_valid_next[s];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            for (int s = 0; s < STAGE_COUNT; s++) begin
                stage_tag_reg[s] <= stage_tag_next[s];
                stage_bcd_reg[s] <= stage_bcd_next[s];
                stage_bin_reg[s] <= stage_bin_next[s];
            end
        end
    end

    assign out_valid = stage_valid_reg[STAGE_COUNT-1];
    assign out_tag   = stage_tag_reg[STAGE_COUNT-1];
    assign out_bcd   = stage_bcd_reg[STAGE_COUNT-1];

endmodule

### hw/rtl/lcc_luhn_classify.sv
// Luhn digit sum and card type decision over the decimal digits.
`timescale 1ns / 1ps

module lcc_luhn_classify
    import lcc_pkg::*;
#(
    parameter int DIGIT_COUNT = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  tag_t                     in_tag,
    input  logic [4*DIGIT_COUNT-1:0] in_bcd,
    output logic                     out_valid,
    output result_beat_t             out_data
);

    localparam int GROUP_SIZE  = 4;
    localparam int GROUP_COUNT = (DIGIT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_BITS  = $clog2(9 * GROUP_SIZE + 1);
    localparam int MAX_SUM     = 9 * DIGIT_COUNT;
    localparam int SUM_BITS    = $clog2(MAX_SUM + 1);

    logic [3:0]            mapped [DIGIT_COUNT];
    logic [GROUP_BITS-1:0] group_reg  [GROUP_COUNT];
    logic [GROUP_BITS-1:0] group_next [GROUP_COUNT];
    logic [7:0]            lead_reg;
    logic [7:0]            lead_next;
    tag_t                  tag_reg;
    logic                  sum_valid_reg;
    logic [SUM_BITS-1:0]   total;
    logic                  sum_ok;
    logic [3:0]            lead_hi;
    logic [3:0]            lead_lo;
    logic                  out_valid_reg;
    result_beat_t          out_data_reg;
    result_beat_t          out_data_next;

    // Map each digit, doubling every second one from the right, and add
    // the mapped digits in small groups.
    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if ((i & 1) == 1) begin
                mapped[i] = luhn_double(in_bcd[4*i +: 4]);
            end else begin
                mapped[i] = in_bcd[4*i +: 4];
            end
        end
        for (int g = 0; g < GROUP_COUNT; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < DIGIT_COUNT) begin
                    group_next[g] = group_next[g]
                                  + GROUP_BITS'(mapped[g * GROUP_SIZE + k]);
                end
            end
        end
    end

    // The two leading digits for the length that the number has.
    always_comb
    begin
        if (in_tag.len16) begin
            lead_next = in_bcd[4*14 +: 8];
        end else if (in_tag.len15) begin
            lead_next = in_bcd[4*13 +: 8];
        end else begin
            lead_next = in_bcd[4*11 +: 8];
        end
    end

    // Partial sum stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_valid_reg <= 1'b0;
        end else if (advance) begin
            sum_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                group_reg[g] <= group_next[g];
            end
            lead_reg <= lead_next;
            tag_reg  <= in_tag;
        end
    end

    // Final sum, check against the multiples of ten, and prefix decision.
    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            total = total + SUM_BITS'(group_reg[g]);
        end
        sum_ok = 1'b0;
        for (int m = 0; m <= MAX_SUM / 10; m++) begin
            if (total == SUM_BITS'(m * 10)) begin
                sum_ok = 1'b1;
            end
        end

        lead_hi = lead_reg[7:4];
        lead_lo = lead_reg[3:0];

        out_data_next.luhn_ok   = tag_reg.in_range && sum_ok;
        out_data_next.card_kind = KIND_INVALID;
        if (out_data_next.luhn_ok) begin
            if (tag_reg.len16) begin
                if (lead_hi == 4'd4) begin
                    out_data_next.card_kind = KIND_VISA;
                end else if (lead_hi == 4'd5 && (lead_lo inside {[4'd1:4'd5]})) begin
                    out_data_next.card_kind = KIND_MASTER;
                end
            end else if (tag_reg.len15) begin
                if (lead_hi == 4'd3 && (lead_lo inside {4'd4, 4'd7})) begin
                    out_data_next.card_kind = KIND_AMEX;
                end
            end else if (tag_reg.len13) begin
                if (lead_hi == 4'd4) begin
                    out_data_next.card_kind = KIND_VISA;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/luhn_card_classifier.sv
// Top level of the Luhn check and card type classifier.
//
// The card channel carries one card number per beat; the result channel
// returns one beat per number with the card kind and the Luhn flag, in order.
// Both channels use valid/ready and a beat moves when both are high.
//
// Pipeline: a number passes through one input register, 19 decimal converter
// stages of 3 binary bits each, one stage of partial Luhn sums and the result
// register.
// Throughput: one number per cycle while the receiver takes results; every stage is a plain pipeline register.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and card ready drops; a new number is still taken in the cycle in which
// the waiting result is taken.
// Reset clears all valid flags at once; items in flight are dropped, none is produced by it,
// and the block accepts numbers from the first cycle after reset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module luhn_card_classifier
    import lcc_pkg::*;
#(
    parameter int DIGIT_COUNT = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    lcc_stream_if.sink   card,
    lcc_stream_if.source result
);

    logic                     advance;
    logic                     card_valid_reg;
    logic [CARD_BITS-1:0]     card_value_reg;
    tag_t                     card_tag;
    logic                     bcd_valid;
    tag_t                     bcd_tag;
    logic [4*DIGIT_COUNT-1:0] bcd_digits;
    logic                     res_valid;
    result_beat_t             res_data;

    // The pipeline moves whenever the result register is free or being taken.
    assign advance    = !res_valid || result.ready;
    assign card.ready = advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            card_valid_reg <= 1'b0;
        end else if (advance) begin
            card_valid_reg <= card.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            card_value_reg <= card.data.card_number;
        end
    end

    // Range and decimal length from the binary value.
    always_comb
    begin
        card_tag.in_range = (card_value_reg >= LOW_BOUND) && (card_value_reg <= HIGH_BOUND);
        card_tag.len16    = (card_value_reg >= TEN_POW_15) && (card_value_reg < TEN_POW_16);
        card_tag.len15    = (card_value_reg >= TEN_POW_14) && (card_value_reg < TEN_POW_15);
        card_tag.len13    = (card_value_reg >= TEN_POW_12) && (card_value_reg < TEN_POW_13);
    end

    lcc_bcd_pipe #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_bcd_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (card_valid_reg),
        .in_tag   (card_tag),
        .in_value (card_value_reg[VALUE_BITS-1:0]),
        .out_valid(bcd_valid),
        .out_tag  (bcd_tag),
        .out_bcd  (bcd_digits)
    );

    lcc_luhn_classify #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_luhn_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (bcd_valid),
        .in_tag   (bcd_tag),
        .in_bcd   (bcd_digits),
        .out_valid(res_valid),
        .out_data (res_data)
    );

    assign result.valid = res_valid;
    assign result.data  = res_data;

    // A stalled pipeline keeps the converted item and its flags in place.
    `LCC_ASSERT(a_stall_holds, clk, rst_n, bcd_valid && !advance |=> bcd_valid && $stable(bcd_tag), "converter output changed during a stall")
    // A decimal length is only flagged for a number inside the card range.
    `LCC_ASSERT(a_len_in_range, clk, rst_n, bcd_valid && (bcd_tag.len16 || bcd_tag.len15 || bcd_tag.len13) |-> bcd_tag.in_range && $onehot0({bcd_tag.len16, bcd_tag.len15, bcd_tag.len13}), "inconsistent length flags")
    // A card type is only reported for a number that passed the Luhn check.
    `LCC_ASSERT(a_kind_needs_luhn, clk, rst_n, res_valid && res_data.card_kind != KIND_INVALID |-> res_data.luhn_ok, "card kind without Luhn pass")
    // No result is offered while reset is held.
    `LCC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !res_valid, "result valid during reset")

endmodule
